// ----- rtl/jpdtc_pkg.sv -----
`default_nettype none
package jpdtc_pkg;

	localparam int DEFAULT_JOINTS     = 16;
	localparam int DEFAULT_VALUE_BITS = 32;
	localparam int IDX_BITS           = 4;
	localparam int FIELD_BITS         = 32;
	localparam int LIMIT_BITS         = 31;
	localparam int CFG_BITS           = 32;

	// 1000.0 in unsigned Q16.16, a one millisecond control period.
	localparam logic [CFG_BITS-1:0] INV_PERIOD_RESET = 32'd65536000;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_CONTROL = 1'b1
	} command_t;

	typedef struct packed {
		command_t                      command;
		logic [IDX_BITS-1:0]           joint_index;
		logic signed [FIELD_BITS-1:0]  measured_position;
		logic signed [FIELD_BITS-1:0]  target_position;
		logic signed [FIELD_BITS-1:0]  target_velocity;
		logic signed [FIELD_BITS-1:0]  position_gain;
		logic signed [FIELD_BITS-1:0]  velocity_gain;
		logic signed [FIELD_BITS-1:0]  feedforward_torque;
		logic [LIMIT_BITS-1:0]         limit_value;
	} req_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]           out_joint_index;
		logic signed [FIELD_BITS-1:0]  torque;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/joint_pd_torque_controller_top.sv -----
`default_nettype none
// Per-joint PD torque controller with feedforward in signed Q16.16. A control request
// estimates velocity as (position - last position) * inverse_period (zero on a joint's
// first request), forms ff + kp*(target_position - position) + kd*(target_velocity -
// velocity) with saturation at every step, clamps it to +/- the joint's effort limit and
// returns one response; a load request stores an effort limit and returns nothing, and
// a request for a joint at or above JOINTS is dropped. All three products share one
// multiplier that takes 16 bits of its second operand per cycle; a control request
// holds req_stall until its response is registered, so no new request is taken before
// the last is through, and a joint's first request skips the velocity product. Last
// positions and effort limits sit in two synchronous memories; per-joint flags make
// the limits read as zero until loaded, so there is no clearing pass after reset. A
// finished response waits in an output register while the next request is taken.
module joint_pd_torque_controller_top #(
	parameter int JOINTS     = jpdtc_pkg::DEFAULT_JOINTS,
	parameter int VALUE_BITS = jpdtc_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [jpdtc_pkg::CFG_BITS-1:0] cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  jpdtc_pkg::req_t                req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output jpdtc_pkg::rsp_t                rsp
);
	import jpdtc_pkg::*;

	localparam int V   = VALUE_BITS;
	localparam int MW  = (V > FIELD_BITS) ? V : FIELD_BITS;
	localparam int NCH = (MW + 15) / 16;
	localparam int BW  = NCH * 16;
	localparam int AW  = MW + BW;
	localparam int QW  = AW - 16;
	localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int CW  = $clog2(NCH + 1);

	localparam logic signed [V-1:0]  VMAX_V  = {1'b0, {(V-1){1'b1}}};
	localparam logic signed [V-1:0]  VMIN_V  = ~VMAX_V;
	localparam logic signed [MW-1:0] VMAX_E  = {{(MW-V+1){1'b0}}, {(V-1){1'b1}}};
	localparam logic signed [MW-1:0] VMIN_E  = ~VMAX_E;
	localparam logic signed [V+1:0]  SUM_MAX = {3'b000, {(V-1){1'b1}}};
	localparam logic signed [V+1:0]  SUM_MIN = ~SUM_MAX;
	localparam logic [QW-1:0]        Q_VMAX  = {{(QW-V+1){1'b0}}, {(V-1){1'b1}}};
	localparam logic [QW-1:0]        Q_HALF  = Q_VMAX + QW'(1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_VERR = 6'b000100,
		S_MUL  = 6'b001000,
		S_FIN  = 6'b010000,
		S_SUM  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		OP_VEL = 2'd0,
		OP_KP  = 2'd1,
		OP_KD  = 2'd2
	} op_t;

	function automatic logic signed [V-1:0] field_in(input logic signed [FIELD_BITS-1:0] x);
		logic signed [MW-1:0] e;
		e = MW'(x);
		if (e > VMAX_E) return VMAX_V;
		if (e < VMIN_E) return VMIN_V;
		return e[V-1:0];
	endfunction

	function automatic logic signed [V-1:0] sat1(input logic signed [V:0] x);
		if (x[V] != x[V-1]) return x[V] ? VMIN_V : VMAX_V;
		return x[V-1:0];
	endfunction

	function automatic logic signed [V-1:0] sat2(input logic signed [V+1:0] x);
		if (x > SUM_MAX) return VMAX_V;
		if (x < SUM_MIN) return VMIN_V;
		return x[V-1:0];
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [V-1:0] x);
		logic [MW-1:0] e;
		e = MW'(x);
		return x[V-1] ? (~e + MW'(1)) : e;
	endfunction

	state_t state_q;
	op_t    op_q;
	logic [CW-1:0] cnt_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic [CFG_BITS-1:0] ip_q;

	logic [JOINTS-1:0] seen_q;
	logic [JOINTS-1:0] limv_q;
	logic signed [V-1:0]    lastpos_mem [JOINTS];
	logic [LIMIT_BITS-1:0]  limit_mem [JOINTS];
	logic signed [V-1:0]    lp_rd_q;
	logic [LIMIT_BITS-1:0]  lim_rd_q;

	logic [JW-1:0]        joint_q;
	logic [IDX_BITS-1:0]  out_idx_q;
	logic signed [V-1:0]  pos_q, tvel_q, kp_q, kd_q, ff_q;
	logic signed [V-1:0]  perr_q, vel_q, verr_q, pterm_q, dterm_q;
	logic                 seen_hit_q, limv_hit_q;

	logic [MW-1:0]    ma_q;
	logic [BW-1:0]    mb_q;
	logic             neg_q;
	logic [AW-1:0]    acc_q;
	logic [MW+15:0]   pp_s1;

	logic accept, in_range, ctrl_go, load_go, rsp_free;
	logic [JW-1:0] idx;
	logic signed [V-1:0] pos_in, tpos_in;
	logic signed [V-1:0] diff_rd;
	logic mul_go, mul_b_neg;
	logic signed [V-1:0] mul_a;
	logic [MW-1:0] mul_b_mag;
	logic [QW-1:0] q;
	logic frac;
	logic signed [V-1:0] mres;
	logic signed [V-1:0] sum;
	logic signed [MW:0] sum_e, lim_e, clamp;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign in_range  = int'(req.joint_index) < JOINTS;
	assign idx       = JW'(req.joint_index);
	assign ctrl_go   = accept && in_range && (req.command == CMD_CONTROL);
	assign load_go   = accept && in_range && (req.command == CMD_LOAD);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pos_in  = field_in(req.measured_position);
	assign tpos_in = field_in(req.target_position);
	assign diff_rd = sat1((V+1)'(pos_q) - (V+1)'(lp_rd_q));

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_go    = 1'b0;
		mul_a     = kp_q;
		mul_b_mag = mag(perr_q);
		mul_b_neg = perr_q[V-1];
		case (state_q)
			S_READ: begin
				if (seen_hit_q) begin
					mul_go    = 1'b1;
					mul_a     = diff_rd;
					mul_b_mag = MW'(ip_q);
					mul_b_neg = 1'b0;
				end
			end
			S_VERR: begin
				mul_go = 1'b1;
			end
			S_FIN: begin
				if (op_q == OP_KP) begin
					mul_go    = 1'b1;
					mul_a     = kd_q;
					mul_b_mag = mag(verr_q);
					mul_b_neg = verr_q[V-1];
				end
			end
			default: begin
			end
		endcase
	end

	// The product is floored to Q16.16 and saturated. For a negative result, flooring adds
	// one to the magnitude when fraction bits are set, which turns -q into ~q.
	always_comb begin
		q    = acc_q[AW-1:16];
		frac = |acc_q[15:0];
		if (!neg_q) begin
			mres = (q > Q_VMAX) ? VMAX_V : q[V-1:0];
		end else if ((q > Q_HALF) || ((q == Q_HALF) && frac)) begin
			mres = VMIN_V;
		end else begin
			mres = frac ? ~q[V-1:0] : -q[V-1:0];
		end
	end

	always_comb begin
		sum   = sat2((V+2)'(ff_q) + (V+2)'(pterm_q) + (V+2)'(dterm_q));
		sum_e = (MW+1)'(sum);
		lim_e = (MW+1)'(limv_hit_q ? lim_rd_q : '0);
		if (sum_e > lim_e) begin
			clamp = lim_e;
		end else if (sum_e < -lim_e) begin
			clamp = -lim_e;
		end else begin
			clamp = sum_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q <= INV_PERIOD_RESET;
		end else if (cfg_write) begin
			ip_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (load_go) begin
			limit_mem[idx] <= req.limit_value;
		end
		if (ctrl_go) begin
			lim_rd_q <= limit_mem[idx];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			lastpos_mem[joint_q] <= pos_q;
		end
		if (ctrl_go) begin
			lp_rd_q <= lastpos_mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			limv_q <= '0;
		end else begin
			if (state_q == S_READ) begin
				seen_q[joint_q] <= 1'b1;
			end
			if (load_go) begin
				limv_q[idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_VEL;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (mul_go) begin
				cnt_q <= '0;
			end else if (state_q == S_MUL) begin
				cnt_q <= cnt_q + CW'(1);
			end

			if ((state_q == S_SUM) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (ctrl_go) state_q <= S_READ;
				end
				S_READ: begin
					if (seen_hit_q) begin
						state_q <= S_MUL;
						op_q    <= OP_VEL;
					end else begin
						state_q <= S_VERR;
					end
				end
				S_VERR: begin
					state_q <= S_MUL;
					op_q    <= OP_KP;
				end
				S_MUL: begin
					if (cnt_q == CW'(NCH)) state_q <= S_FIN;
				end
				S_FIN: begin
					case (op_q)
						OP_VEL: state_q <= S_VERR;
						OP_KP: begin
							state_q <= S_MUL;
							op_q    <= OP_KD;
						end
						OP_KD: state_q <= S_SUM;
						default: state_q <= S_IDLE;
					endcase
				end
				S_SUM: begin
					if (rsp_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Multiplier: one 16-bit slice of the second operand per cycle, the partial
	// product registered and then folded into a right-shifting accumulator.
	always_ff @(posedge clk) begin
		if (mul_go) begin
			ma_q  <= mag(mul_a);
			mb_q  <= BW'(mul_b_mag);
			neg_q <= mul_a[V-1] ^ mul_b_neg;
			acc_q <= '0;
		end else if (state_q == S_MUL) begin
			pp_s1 <= ma_q * mb_q[15:0];
			mb_q  <= mb_q >> 16;
			if (cnt_q != '0) begin
				acc_q <= (acc_q >> 16) + (AW'(pp_s1) << (BW - 16));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_go) begin
			joint_q    <= idx;
			out_idx_q  <= req.joint_index;
			pos_q      <= pos_in;
			tvel_q     <= field_in(req.target_velocity);
			kp_q       <= field_in(req.position_gain);
			kd_q       <= field_in(req.velocity_gain);
			ff_q       <= field_in(req.feedforward_torque);
			perr_q     <= sat1((V+1)'(tpos_in) - (V+1)'(pos_in));
			seen_hit_q <= seen_q[idx];
			limv_hit_q <= limv_q[idx];
		end
		if ((state_q == S_READ) && !seen_hit_q) begin
			vel_q <= '0;
		end
		if (state_q == S_VERR) begin
			verr_q <= sat1((V+1)'(tvel_q) - (V+1)'(vel_q));
		end
		if (state_q == S_FIN) begin
			case (op_q)
				OP_VEL:  vel_q   <= mres;
				OP_KP:   pterm_q <= mres;
				OP_KD:   dterm_q <= mres;
				default: begin
				end
			endcase
		end
		if ((state_q == S_SUM) && rsp_free) begin
			rsp_q.out_joint_index <= out_idx_q;
			rsp_q.torque          <= clamp[FIELD_BITS-1:0];
		end
	end

endmodule
`default_nettype wire
